// ===== rtl/core/adcmf_pkg.sv =====
package adcmf_pkg;

  localparam int VAL_W      = 12;
  localparam int CHAN_IDX_W = 4;
  localparam int CFG_DATA_W = 5;
  localparam int REG_IDX_W  = 1;
  localparam int SLOT_W     = 8;
  localparam int MAX_SETS   = 12;
  localparam int READS_W    = 4;

  localparam logic [CFG_DATA_W-1:0] CHANS_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_MED3 = 2'd1,
    MODE_MED9 = 2'd2,
    MODE_AVG4 = 2'd3
  } mode_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILTER_MODE = 1'b0,
    REG_CHANNELS    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  operation;
    logic [VAL_W-1:0]      sample_value;
    logic [CHAN_IDX_W-1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] filtered_value;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_item_t;

  // store reads needed per read item
  function automatic logic [READS_W-1:0] reads_for_mode(mode_t m);
    logic [READS_W-1:0] r;
    unique case (m)
      MODE_RAW:  r = 4'd1;
      MODE_MED3: r = 4'd3;
      MODE_MED9: r = 4'd9;
      MODE_AVG4: r = 4'd12;
      default:   r = 4'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/adcmf_if.sv =====
interface adcmf_in_if;
  logic                valid;
  logic                ready;
  adcmf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adcmf_out_if;
  logic                 valid;
  logic                 ready;
  adcmf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adcmf_cfg_if;
  logic                 valid;
  logic                 ready;
  adcmf_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/adc_median_filter_bank.sv =====
// Multi-channel ADC sample store with median filtering. Store items are written on acceptance
// and land in a circular store in scan order (slot = set * channels + channel, wrapping
// after 1, 3, 9 or 12 sets by filter mode). A read item walks the store through its single
// read port, one sample per cycle, feeding one shared median-of-three unit: it makes 1, 3,
// 9 or 12 store reads in modes 0..3, then passes through RAM read, median, combine and
// output load before a valid result. in_ready is low while a read is in progress; store
// items are still taken while a finished result waits on the output.
// The store needs no clearing pass after reset: per-entry valid bits make unwritten
// entries read as zero. Reads of a channel at or above the channel count return zero.
module adc_median_filter_bank #(
  parameter int NUM_CHANNELS = 16,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  adcmf_in_if.sink         in_if,
  adcmf_out_if.source      out_if,
  adcmf_cfg_if.sink        cfg_if
);

  import adcmf_pkg::*;

  localparam int DEPTH = MAX_SETS * NUM_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(NUM_CHANNELS + 1);
  localparam int SW    = SAMPLE_BITS;
  localparam int ACC_W = SAMPLE_BITS + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                  st_r;
  mode_t                   mode_r;
  logic [CFG_DATA_W-1:0]   chans_r;
  logic [SLOT_W-1:0]       wslot_r;
  logic [SLOT_W-1:0]       wslot;
  logic [SLOT_W-1:0]       wslot_inc;
  logic [SLOT_W-1:0]       wslot_nxt;
  logic [SLOT_W-1:0]       limit;
  logic [SLOT_W-1:0]       n8;
  logic [NW-1:0]           n;
  logic [DEPTH-1:0]        valid_r;
  logic                    out_valid_r;
  logic [VAL_W-1:0]        out_val_r;

  logic [AW-1:0]           addr_r;
  logic [READS_W-1:0]      issue_cnt_r;
  logic [READS_W-1:0]      total_reads;
  logic [1:0]              tri_r;
  logic [1:0]              grp_r;
  logic                    rd_pend_r;
  logic                    rd_hit_r;
  logic                    med_pend_r;
  logic [SW-1:0]           s0_r;
  logic [SW-1:0]           s1_r;
  logic [SW-1:0]           med_r;
  logic [SW-1:0]           m0_r;
  logic [SW-1:0]           m1_r;
  logic [SW-1:0]           res_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        acc_nxt;

  logic                    in_fire;
  logic                    store_fire;
  logic                    read_fire;
  logic                    ch_used;
  logic                    rd_issue;
  logic                    med_load;
  logic                    fin;
  logic                    grp_sel;
  logic [SW-1:0]           ram_q;
  logic [SW-1:0]           rd_data;
  logic [SW-1:0]           med_a;
  logic [SW-1:0]           med_b;
  logic [SW-1:0]           med_c;
  logic [SW-1:0]           med_out;

  function automatic logic [SW-1:0] med3(logic [SW-1:0] a, logic [SW-1:0] b,
                                         logic [SW-1:0] c);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [SW-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // clamp channel count to 1..NUM_CHANNELS
  always_comb begin
    if (chans_r == '0) begin
      n = NW'(1);
    end else if (int'(chans_r) > NUM_CHANNELS) begin
      n = NW'(NUM_CHANNELS);
    end else begin
      n = NW'(chans_r);
    end
  end

  assign n8 = SLOT_W'(n);

  always_comb begin
    unique case (mode_r)
      MODE_RAW:  limit = n8;
      MODE_MED3: limit = (n8 << 1) + n8;
      MODE_MED9: limit = (n8 << 3) + n8;
      MODE_AVG4: limit = (n8 << 3) + (n8 << 2);
      default:   limit = n8;
    endcase
  end

  assign total_reads = reads_for_mode(mode_r);

  assign in_if.ready  = (st_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign store_fire   = in_fire && (in_if.data.operation == OP_STORE);
  assign read_fire    = in_fire && (in_if.data.operation == OP_READ);
  assign ch_used      = int'(in_if.data.channel) < int'(n);

  // stale slot after a register change restarts at zero
  assign wslot     = (wslot_r < limit) ? wslot_r : '0;
  assign wslot_inc = wslot + SLOT_W'(1);
  assign wslot_nxt = (wslot_inc >= limit) ? '0 : wslot_inc;

  assign rd_issue = (st_r == ST_RUN) && (issue_cnt_r != total_reads);
  assign rd_data  = rd_hit_r ? ram_q : '0;
  assign med_load = rd_pend_r && ((mode_r == MODE_RAW) || (tri_r == 2'd2));

  // shared median unit: sample triples, or the three group medians in mode 2
  assign grp_sel = med_pend_r && (mode_r == MODE_MED9) && (grp_r == 2'd2);
  assign med_a   = grp_sel ? m0_r : s0_r;
  assign med_b   = grp_sel ? m1_r : s1_r;
  assign med_c   = grp_sel ? med_r : rd_data;
  assign med_out = med3(med_a, med_b, med_c);

  assign acc_nxt = acc_r + ACC_W'(med_r);

  always_comb begin
    fin = 1'b0;
    if (med_pend_r) begin
      unique case (mode_r)
        MODE_RAW, MODE_MED3: fin = 1'b1;
        MODE_MED9:           fin = (grp_r == 2'd2);
        MODE_AVG4:           fin = (grp_r == 2'd3);
        default:             fin = 1'b1;
      endcase
    end
  end

  adcmf_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_fire),
    .waddr (wslot[AW-1:0]),
    .wdata (SW'(in_if.data.sample_value)),
    .raddr (addr_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mode_r      <= MODE_RAW;
      chans_r     <= CHANS_RESET;
      wslot_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      med_pend_r  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (reg_idx_t'(cfg_if.data.reg_index))
          REG_FILTER_MODE: mode_r  <= mode_t'(cfg_if.data.wr_data[1:0]);
          REG_CHANNELS:    chans_r <= cfg_if.data.wr_data;
          default:         chans_r <= chans_r;
        endcase
      end
      if (store_fire) begin
        valid_r[wslot[AW-1:0]] <= 1'b1;
        wslot_r                <= wslot_nxt;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_if.ready && (st_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r  <= rd_issue;
      med_pend_r <= med_load;
      unique case (st_r)
        ST_IDLE: begin
          if (read_fire) begin
            st_r <= ch_used ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (fin) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= VAL_W'(res_r);
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      addr_r      <= AW'(in_if.data.channel);
      issue_cnt_r <= '0;
      tri_r       <= '0;
      grp_r       <= '0;
      acc_r       <= '0;
      res_r       <= '0;
    end
    if (rd_issue) begin
      addr_r      <= addr_r + AW'(n);
      issue_cnt_r <= issue_cnt_r + READS_W'(1);
      rd_hit_r    <= valid_r[addr_r];
    end
    if (rd_pend_r) begin
      if (mode_r == MODE_RAW) begin
        med_r <= rd_data;
      end else begin
        case (tri_r)
          2'd0:    s0_r  <= rd_data;
          2'd1:    s1_r  <= rd_data;
          default: med_r <= med_out;
        endcase
        tri_r <= (tri_r == 2'd2) ? 2'd0 : tri_r + 2'd1;
      end
    end
    if (med_pend_r) begin
      grp_r <= grp_r + 2'd1;
      unique case (mode_r)
        MODE_RAW, MODE_MED3: res_r <= med_r;
        MODE_MED9: begin
          case (grp_r)
            2'd0:    m0_r  <= med_r;
            2'd1:    m1_r  <= med_r;
            default: res_r <= med_out;
          endcase
        end
        MODE_AVG4: begin
          acc_r <= acc_nxt;
          if (grp_r == 2'd3) begin
            res_r <= acc_nxt[ACC_W-1:2];
          end
        end
        default: res_r <= med_r;
      endcase
    end
  end

  assign out_if.valid               = out_valid_r;
  assign out_if.data.filtered_value = out_val_r;

  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> st_r == ST_RUN)
    else $error("store read returned outside a read sequence");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN |-> issue_cnt_r <= total_reads)
    else $error("more store reads issued than the mode needs");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    store_fire |-> wslot < limit)
    else $error("store item written past the active ring");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("result presented without a finished read");

endmodule

// ===== rtl/core/adcmf_ram.sv =====
module adcmf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
